FILE: rtl/pwbl_pkg.sv
// Shared types, constants and arithmetic helpers for the particle wall bounce and lysis block.
`default_nettype none
package pwbl_pkg;

   // Configuration register indexes
   localparam logic [1:0] CSR_BROWNIAN = 2'd0;
   localparam logic [1:0] CSR_RADIUS   = 2'd1;
   localparam logic [1:0] CSR_RATE     = 2'd2;
   localparam logic [1:0] CSR_HALFMAX  = 2'd3;

   // Register reset values
   localparam logic        BROWNIAN_RST = 1'b0;
   localparam logic [22:0] RADIUS_RST   = 23'd76800;
   localparam logic [15:0] RATE_RST     = 16'd256;
   localparam logic [31:0] HALFMAX_RST  = 32'd65536;

   // Normalizer geometry: 24-bit root, two root bits per stage
   localparam int RAD_W       = 48;
   localparam int ROOT_W      = 24;
   localparam int SQRT_STAGES = ROOT_W / 2;
   // Unit vector magnitude quotient: 16 bits, two bits per stage
   localparam int QUO_W       = 16;
   localparam int DIV_STAGES  = QUO_W / 2;

   // Item state that travels alongside the normalizer
   typedef struct packed {
      logic signed [23:0] pos_x;
      logic signed [23:0] pos_y;
      logic signed [15:0] vel_x;
      logic signed [15:0] vel_y;
      logic               hit;
      logic               destroy;
   } side_type;

   // Signed shift right by k, rounded to nearest, ties away from zero
   function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] n,
                                                  input int unsigned k);
      logic [63:0] mag;
      logic [63:0] q;
      mag = n[63] ? (64'd0 - n) : n;
      q   = (mag + (64'd1 << (k - 1))) >> k;
      return $signed(n[63] ? (64'd0 - q) : q);
   endfunction

   function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
      if (v > 64'sd8388607) return 24'sh7FFFFF;
      if (v < -64'sd8388608) return 24'sh800000;
      return v[23:0];
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
      if (v > 64'sd32767) return 16'sh7FFF;
      if (v < -64'sd32768) return 16'sh8000;
      return v[15:0];
   endfunction

endpackage
`default_nettype wire

FILE: rtl/pwbl_norm.sv
// Pipelined radial normalizer: integer square root, then unit vector magnitudes in Q1.15.
`default_nettype none
module pwbl_norm (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               adv,
   input  wire logic               in_valid,
   input  wire pwbl_pkg::side_type in_side,
   input  wire logic [47:0]        in_r2,
   output logic                    out_valid,
   output pwbl_pkg::side_type      out_side,
   output logic [15:0]             out_qx,
   output logic [15:0]             out_qy
);
   import pwbl_pkg::*;

   typedef struct packed {
      logic [26:0]       rem;
      logic [ROOT_W-1:0] root;
      logic [RAD_W-1:0]  rad;
   } sq_type;

   typedef struct packed {
      logic [24:0]       rem_x;
      logic [24:0]       rem_y;
      logic [QUO_W-1:0]  num_x;
      logic [QUO_W-1:0]  num_y;
      logic [QUO_W-1:0]  q_x;
      logic [QUO_W-1:0]  q_y;
      logic [ROOT_W-1:0] len;
   } dv_type;

   // Two digit-by-digit square root iterations
   function automatic sq_type sq_step(input sq_type a);
      sq_type      s;
      logic [26:0] trial;
      s = a;
      for (int i = 0; i < 2; i++) begin
         s.rem = {s.rem[24:0], s.rad[RAD_W-1 -: 2]};
         s.rad = {s.rad[RAD_W-3:0], 2'b00};
         trial = {1'b0, s.root, 2'b01};
         if (s.rem >= trial) begin
            s.rem  = s.rem - trial;
            s.root = {s.root[ROOT_W-2:0], 1'b1};
         end else begin
            s.root = {s.root[ROOT_W-2:0], 1'b0};
         end
      end
      return s;
   endfunction

   // Two restoring division iterations on both axes
   function automatic dv_type dv_step(input dv_type a);
      dv_type      s;
      logic [24:0] lenx;
      s    = a;
      lenx = {1'b0, a.len};
      for (int i = 0; i < 2; i++) begin
         s.rem_x = {s.rem_x[23:0], s.num_x[QUO_W-1]};
         s.num_x = {s.num_x[QUO_W-2:0], 1'b0};
         if (s.rem_x >= lenx) begin
            s.rem_x = s.rem_x - lenx;
            s.q_x   = {s.q_x[QUO_W-2:0], 1'b1};
         end else begin
            s.q_x   = {s.q_x[QUO_W-2:0], 1'b0};
         end
         s.rem_y = {s.rem_y[23:0], s.num_y[QUO_W-1]};
         s.num_y = {s.num_y[QUO_W-2:0], 1'b0};
         if (s.rem_y >= lenx) begin
            s.rem_y = s.rem_y - lenx;
            s.q_y   = {s.q_y[QUO_W-2:0], 1'b1};
         end else begin
            s.q_y   = {s.q_y[QUO_W-2:0], 1'b0};
         end
      end
      return s;
   endfunction

   sq_type   sq_in     [SQRT_STAGES];
   sq_type   sq_ff     [SQRT_STAGES];
   side_type sq_side_ff[SQRT_STAGES];
   logic     sq_valid_ff[SQRT_STAGES];

   dv_type   dv_in     [DIV_STAGES];
   dv_type   dv_ff     [DIV_STAGES];
   side_type dv_side_ff[DIV_STAGES];
   logic     dv_valid_ff[DIV_STAGES];

   dv_type   ds_ff;
   dv_type   ds_in;
   side_type ds_side_ff;
   logic     ds_valid_ff;

   logic [23:0] abs_x;
   logic [23:0] abs_y;
   logic [38:0] num_x;
   logic [38:0] num_y;

   // Square root stages
   for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_sqrt
      sq_type   sq_prev;
      side_type side_prev;
      logic     valid_prev;

      // Feed from the input or from the previous stage
      if (g == 0) begin : g_head
         assign sq_prev    = '{rem: 27'd0, root: '0, rad: in_r2};
         assign side_prev  = in_side;
         assign valid_prev = in_valid;
      end else begin : g_body
         assign sq_prev    = sq_ff[g-1];
         assign side_prev  = sq_side_ff[g-1];
         assign valid_prev = sq_valid_ff[g-1];
      end

      always_comb begin
         sq_in[g] = sq_step(sq_prev);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_valid_ff[g] <= 1'b0;
         end else if (adv) begin
            sq_valid_ff[g] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sq_ff[g]      <= sq_in[g];
            sq_side_ff[g] <= side_prev;
         end
      end
   end

   // Division setup: magnitude scaled by 2^15 plus half the length
   always_comb begin
      abs_x = sq_side_ff[SQRT_STAGES-1].pos_x[23]
              ? 24'(-sq_side_ff[SQRT_STAGES-1].pos_x) : sq_side_ff[SQRT_STAGES-1].pos_x;
      abs_y = sq_side_ff[SQRT_STAGES-1].pos_y[23]
              ? 24'(-sq_side_ff[SQRT_STAGES-1].pos_y) : sq_side_ff[SQRT_STAGES-1].pos_y;
      num_x = {abs_x, 15'd0} + 39'(sq_ff[SQRT_STAGES-1].root >> 1);
      num_y = {abs_y, 15'd0} + 39'(sq_ff[SQRT_STAGES-1].root >> 1);
      ds_in.rem_x = {2'b00, num_x[38:16]};
      ds_in.rem_y = {2'b00, num_y[38:16]};
      ds_in.num_x = num_x[15:0];
      ds_in.num_y = num_y[15:0];
      ds_in.q_x   = '0;
      ds_in.q_y   = '0;
      ds_in.len   = sq_ff[SQRT_STAGES-1].root;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ds_valid_ff <= 1'b0;
      end else if (adv) begin
         ds_valid_ff <= sq_valid_ff[SQRT_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ds_ff      <= ds_in;
         ds_side_ff <= sq_side_ff[SQRT_STAGES-1];
      end
   end

   // Division stages
   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
      dv_type   dv_prev;
      side_type side_prev;
      logic     valid_prev;

      // Feed from the setup register or from the previous stage
      if (g == 0) begin : g_head
         assign dv_prev    = ds_ff;
         assign side_prev  = ds_side_ff;
         assign valid_prev = ds_valid_ff;
      end else begin : g_body
         assign dv_prev    = dv_ff[g-1];
         assign side_prev  = dv_side_ff[g-1];
         assign valid_prev = dv_valid_ff[g-1];
      end

      always_comb begin
         dv_in[g] = dv_step(dv_prev);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[g] <= 1'b0;
         end else if (adv) begin
            dv_valid_ff[g] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dv_ff[g]      <= dv_in[g];
            dv_side_ff[g] <= side_prev;
         end
      end
   end

   assign out_valid = dv_valid_ff[DIV_STAGES-1];
   assign out_side  = dv_side_ff[DIV_STAGES-1];
   assign out_qx    = dv_ff[DIV_STAGES-1].q_x;
   assign out_qy    = dv_ff[DIV_STAGES-1].q_y;

endmodule
`default_nettype wire

FILE: rtl/particle_wall_bounce_lysis.sv
// Top level: particle move, wall reflection and lysis decision, fully pipelined.
// Stages from an input transfer to its result: 4 front stages, 12 square root stages,
// 1 division setup, 8 division stages, 4 reflection stages.
// Throughput: one item per cycle while no result is stalled; the square root and division run two bits per stage.
// A stalled result freezes the whole pipeline; no item is lost or repeated.
// Reset clears all valid bits and restores the configuration registers.
`default_nettype none
module particle_wall_bounce_lysis (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic signed [23:0] req_pos_x,
   input  wire logic signed [23:0] req_pos_y,
   input  wire logic signed [15:0] req_vel_x,
   input  wire logic signed [15:0] req_vel_y,
   input  wire logic signed [15:0] req_rand_vel_x,
   input  wire logic signed [15:0] req_rand_vel_y,
   input  wire logic [15:0]        req_step_time,
   input  wire logic [15:0]        req_lysis_conc,
   input  wire logic [15:0]        req_rand_unit,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [23:0]      rsp_new_pos_x,
   output logic signed [23:0]      rsp_new_pos_y,
   output logic signed [15:0]      rsp_new_vel_x,
   output logic signed [15:0]      rsp_new_vel_y,
   output logic                    rsp_hit_wall,
   output logic                    rsp_destroy,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [1:0]         csr_index,
   input  wire logic [31:0]        csr_data
);
   import pwbl_pkg::*;

   logic adv;

   logic        brownian_ff;
   logic [22:0] radius_ff;
   logic [15:0] rate_ff;
   logic [31:0] halfmax_ff;

   // Stage 1
   logic               s1_valid_ff;
   logic signed [23:0] s1_px_ff, s1_py_ff;
   logic signed [15:0] s1_vx_ff, s1_vy_ff;
   logic signed [32:0] s1_mx_ff, s1_my_ff;
   logic [31:0]        s1_l2_ff;
   logic [15:0]        s1_u_ff;
   logic signed [15:0] vsel_x, vsel_y;

   // Stage 2
   logic               s2_valid_ff;
   logic signed [23:0] s2_px_ff, s2_py_ff;
   logic signed [15:0] s2_vx_ff, s2_vy_ff;
   logic [32:0]        s2_d_ff;
   logic [47:0]        s2_rl_ff;
   logic [15:0]        s2_u_ff;

   // Stage 3
   logic               s3_valid_ff;
   logic signed [23:0] s3_px_ff, s3_py_ff;
   logic signed [15:0] s3_vx_ff, s3_vy_ff;
   logic [47:0]        s3_xx_ff, s3_yy_ff;
   logic [45:0]        s3_rr_ff;
   logic [48:0]        s3_ud_ff;
   logic [63:0]        s3_rl65_ff;
   logic               s3_dnz_ff;

   // Stage 4
   logic               s4_valid_ff;
   side_type           s4_side_ff;
   side_type           s4_side_in;
   logic [47:0]        s4_r2_ff;
   logic [47:0]        s4_r2_in;

   // Normalizer output
   logic               nm_valid;
   side_type           nm_side;
   logic [15:0]        nm_qx, nm_qy;

   // Reflection stages
   logic               ra_valid_ff;
   side_type           ra_side_ff;
   logic signed [16:0] ra_ux_ff, ra_uy_ff;
   logic signed [32:0] ra_px_ff, ra_py_ff;
   logic signed [16:0] ux_in, uy_in;

   logic               rb_valid_ff;
   side_type           rb_side_ff;
   logic signed [16:0] rb_ux_ff, rb_uy_ff;
   logic signed [33:0] rb_d_ff;

   logic               rc_valid_ff;
   side_type           rc_side_ff;
   logic signed [50:0] rc_dx_ff, rc_dy_ff;
   logic signed [40:0] rc_wx_ff, rc_wy_ff;

   logic               out_valid_ff;
   logic signed [23:0] out_px_ff, out_py_ff;
   logic signed [15:0] out_vx_ff, out_vy_ff;
   logic               out_hit_ff, out_destroy_ff;

   // Whole pipeline advances unless a result waits on a stalled consumer
   assign adv       = !(out_valid_ff && rsp_stall);
   assign req_stall = !adv;
   assign csr_ready = 1'b1;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         brownian_ff <= BROWNIAN_RST;
         radius_ff   <= RADIUS_RST;
         rate_ff     <= RATE_RST;
         halfmax_ff  <= HALFMAX_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_BROWNIAN: brownian_ff <= csr_data[0];
            CSR_RADIUS:   radius_ff   <= csr_data[22:0];
            CSR_RATE:     rate_ff     <= csr_data[15:0];
            CSR_HALFMAX:  halfmax_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // Valid bits of the front and back stages
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         ra_valid_ff  <= 1'b0;
         rb_valid_ff  <= 1'b0;
         rc_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= req_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         ra_valid_ff  <= nm_valid;
         rb_valid_ff  <= ra_valid_ff;
         rc_valid_ff  <= rb_valid_ff;
         out_valid_ff <= rc_valid_ff;
      end
   end

   // Stage 1: velocity select, displacement products, L squared
   assign vsel_x = brownian_ff ? req_rand_vel_x : req_vel_x;
   assign vsel_y = brownian_ff ? req_rand_vel_y : req_vel_y;

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_px_ff <= req_pos_x;
         s1_py_ff <= req_pos_y;
         s1_vx_ff <= vsel_x;
         s1_vy_ff <= vsel_y;
         s1_mx_ff <= 33'(vsel_x * $signed({1'b0, req_step_time}));
         s1_my_ff <= 33'(vsel_y * $signed({1'b0, req_step_time}));
         s1_l2_ff <= 32'(req_lysis_conc) * 32'(req_lysis_conc);
         s1_u_ff  <= req_rand_unit;
      end
   end

   // Stage 2: move with rounding and saturation; lysis denominator and numerator
   always_ff @(posedge clock) begin
      if (adv) begin
         s2_px_ff <= sat24(64'(s1_px_ff) + rnd_shr(64'(s1_mx_ff), 16));
         s2_py_ff <= sat24(64'(s1_py_ff) + rnd_shr(64'(s1_my_ff), 16));
         s2_vx_ff <= s1_vx_ff;
         s2_vy_ff <= s1_vy_ff;
         s2_d_ff  <= {1'b0, halfmax_ff} + {1'b0, s1_l2_ff};
         s2_rl_ff <= 48'(rate_ff) * 48'(s1_l2_ff);
         s2_u_ff  <= s1_u_ff;
      end
   end

   // Stage 3: squares for the wall test; lysis products
   always_ff @(posedge clock) begin
      if (adv) begin
         s3_px_ff   <= s2_px_ff;
         s3_py_ff   <= s2_py_ff;
         s3_vx_ff   <= s2_vx_ff;
         s3_vy_ff   <= s2_vy_ff;
         s3_xx_ff   <= 48'(s2_px_ff * s2_px_ff);
         s3_yy_ff   <= 48'(s2_py_ff * s2_py_ff);
         s3_rr_ff   <= 46'(radius_ff) * 46'(radius_ff);
         s3_ud_ff   <= 49'(s2_u_ff) * 49'(s2_d_ff);
         s3_rl65_ff <= {s2_rl_ff, 16'd0} - 64'(s2_rl_ff);
         s3_dnz_ff  <= (s2_d_ff != 33'd0);
      end
   end

   // Stage 4: radius squared compare and lysis compare
   always_comb begin
      s4_r2_in           = s3_xx_ff + s3_yy_ff;
      s4_side_in.pos_x   = s3_px_ff;
      s4_side_in.pos_y   = s3_py_ff;
      s4_side_in.vel_x   = s3_vx_ff;
      s4_side_in.vel_y   = s3_vy_ff;
      s4_side_in.hit     = (s4_r2_in > 48'(s3_rr_ff));
      s4_side_in.destroy = s3_dnz_ff && ({7'd0, s3_ud_ff, 8'd0} <= s3_rl65_ff);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_side_ff <= s4_side_in;
         s4_r2_ff   <= s4_r2_in;
      end
   end

   pwbl_norm u_norm (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (s4_valid_ff),
      .in_side   (s4_side_ff),
      .in_r2     (s4_r2_ff),
      .out_valid (nm_valid),
      .out_side  (nm_side),
      .out_qx    (nm_qx),
      .out_qy    (nm_qy)
   );

   // Stage A: signed unit vector, velocity projections
   assign ux_in = nm_side.pos_x[23] ? -$signed({1'b0, nm_qx}) : $signed({1'b0, nm_qx});
   assign uy_in = nm_side.pos_y[23] ? -$signed({1'b0, nm_qy}) : $signed({1'b0, nm_qy});

   always_ff @(posedge clock) begin
      if (adv) begin
         ra_side_ff <= nm_side;
         ra_ux_ff   <= ux_in;
         ra_uy_ff   <= uy_in;
         ra_px_ff   <= 33'(nm_side.vel_x * ux_in);
         ra_py_ff   <= 33'(nm_side.vel_y * uy_in);
      end
   end

   // Stage B: dot product
   always_ff @(posedge clock) begin
      if (adv) begin
         rb_side_ff <= ra_side_ff;
         rb_ux_ff   <= ra_ux_ff;
         rb_uy_ff   <= ra_uy_ff;
         rb_d_ff    <= 34'(ra_px_ff) + 34'(ra_py_ff);
      end
   end

   // Stage C: normal component and position on the wall
   always_ff @(posedge clock) begin
      if (adv) begin
         rc_side_ff <= rb_side_ff;
         rc_dx_ff   <= 51'(rb_d_ff * rb_ux_ff);
         rc_dy_ff   <= 51'(rb_d_ff * rb_uy_ff);
         rc_wx_ff   <= 41'($signed({1'b0, radius_ff}) * rb_ux_ff);
         rc_wy_ff   <= 41'($signed({1'b0, radius_ff}) * rb_uy_ff);
      end
   end

   // Output register: reflected or passed through
   always_ff @(posedge clock) begin
      if (adv) begin
         out_hit_ff     <= rc_side_ff.hit;
         out_destroy_ff <= rc_side_ff.destroy;
         if (rc_side_ff.hit) begin
            out_vx_ff <= sat16(64'(rc_side_ff.vel_x) - rnd_shr(64'(rc_dx_ff), 29));
            out_vy_ff <= sat16(64'(rc_side_ff.vel_y) - rnd_shr(64'(rc_dy_ff), 29));
            out_px_ff <= sat24(rnd_shr(64'(rc_wx_ff), 15));
            out_py_ff <= sat24(rnd_shr(64'(rc_wy_ff), 15));
         end else begin
            out_vx_ff <= rc_side_ff.vel_x;
            out_vy_ff <= rc_side_ff.vel_y;
            out_px_ff <= rc_side_ff.pos_x;
            out_py_ff <= rc_side_ff.pos_y;
         end
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_new_pos_x = out_px_ff;
   assign rsp_new_pos_y = out_py_ff;
   assign rsp_new_vel_x = out_vx_ff;
   assign rsp_new_vel_y = out_vy_ff;
   assign rsp_hit_wall  = out_hit_ff;
   assign rsp_destroy   = out_destroy_ff;

endmodule
`default_nettype wire

FILE: rtl/pwbl_check.sv
// Port-level checker for the particle wall bounce and lysis block, with its bind.
`default_nettype none
module pwbl_check (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [23:0] rsp_new_pos_x,
   input wire logic [15:0] rsp_new_vel_x
);

   // A stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // A stalled result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_new_pos_x) && $stable(rsp_new_vel_x))
      else $error("result payload changed while stalled");

   // A blocked output freezes the pipeline, so input must stall too
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("input accepted while pipeline frozen");

   // Reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result offered right after reset");

endmodule

bind particle_wall_bounce_lysis pwbl_check u_pwbl_check (
   .clock         (clock),
   .reset         (reset),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_new_pos_x (rsp_new_pos_x),
   .rsp_new_vel_x (rsp_new_vel_x)
);
`default_nettype wire
